// ----- rtl/md5_pkg.sv -----
`timescale 1ns / 1ps

package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [3:0] LEN_LO_WORD = 4'd14;
	localparam logic [3:0] LEN_HI_WORD = 4'd15;

	// Write port of the block buffer: byte writes from the stream and the pad
	// sweep, word writes for the length field.
	typedef struct packed {
		logic        byte_we;
		logic [5:0]  byte_addr;
		logic [7:0]  byte_data;
		logic        word_we;
		logic [3:0]  word_addr;
		logic [31:0] word_data;
	} md5_buf_wr_t;

	function automatic logic [31:0] md5_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Rotate amount, indexed by {round group, round[1:0]}.
	function automatic logic [4:0] md5_rot(input logic [3:0] sel);
		logic [4:0] s;
		case (sel)
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word used by a round; the multiples of 16 drop out modulo 16.
	function automatic logic [3:0] md5_msg_idx(input logic [5:0] r);
		logic [3:0] idx;
		case (r[5:4])
			2'd0:    idx = r[3:0];
			2'd1:    idx = 4'(4'd5 * r[3:0] + 4'd1);
			2'd2:    idx = 4'(4'd3 * r[3:0] + 4'd5);
			default: idx = 4'(4'd7 * r[3:0]);
		endcase
		return idx;
	endfunction

endpackage

// ----- rtl/md5_blk_buf.sv -----
`timescale 1ns / 1ps

module md5_blk_buf import md5_pkg::*; (
	input  logic        clk,
	input  md5_buf_wr_t wr,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem_q [16];
	logic [31:0] rd_q;

	// Bytes land little-endian within each word. Reads are registered.
	always_ff @(posedge clk) begin
		if (wr.word_we) begin
			mem_q[wr.word_addr] <= wr.word_data;
		end else if (wr.byte_we) begin
			mem_q[wr.byte_addr[5:2]][{wr.byte_addr[1:0], 3'b000} +: 8] <= wr.byte_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/md5_round_unit.sv -----
`timescale 1ns / 1ps

module md5_round_unit import md5_pkg::*; (
	input  logic [5:0]  rnd,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] msg_word,
	output logic [31:0] b_next
);

	logic [31:0] fv;
	logic [31:0] sum;
	logic [4:0]  sh;
	logic [63:0] dbl;

	always_comb begin
		case (rnd[5:4])
			2'd0: begin
				fv = (b & c) | (~b & d);
			end
			2'd1: begin
				fv = (d & b) | (~d & c);
			end
			2'd2: begin
				fv = b ^ c ^ d;
			end
			default: begin
				fv = c ^ (b | ~d);
			end
		endcase
	end

	assign sum    = a + fv + md5_k(rnd) + msg_word;
	assign sh     = md5_rot({rnd[5:4], rnd[1:0]});
	assign dbl    = {sum, sum} << sh;
	assign b_next = b + dbl[63:32];

endmodule

// ----- rtl/md5_message_digest_unit.sv -----
`timescale 1ns / 1ps

// MD5 digest engine fed one message byte per input beat. s_tdata carries the
// byte, s_tuser[0] says the byte belongs to the message, and s_tlast closes
// the message after that beat's byte (a beat with s_tlast and no byte closes
// it too, and an empty message gives the standard empty-message digest). On
// close the engine pads, appends the bit length and returns four beats, words
// a, b, c, d with word index in m_tuser and m_tlast on word d; printing each
// word's bytes lowest first gives the usual hex digest. The engine then
// restarts from the initial vector. Every 64th byte fills the block and the
// single shared round unit runs the 64 rounds one per cycle and then folds
// the working words into the chaining words. Closing a message sweeps the
// rest of the block one byte per cycle, writes the length as two words and
// compresses once more (twice, with a second sweep of zero bytes, when the
// 0x80 marker lands in the last 8 bytes of the block), then holds the four
// result beats until taken. s_tready is low whenever the round unit, the pad
// sweep, the length writes or the result beats are busy.
module md5_message_digest_unit import md5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [1:0]  m_tuser,   // [1:0] word_index
	output logic        m_tlast    // last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_LEN0  = 3'd4;
	localparam logic [2:0] ST_LEN1  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	// What to do once a compression has been folded in.
	localparam logic [1:0] AFT_IDLE = 2'd0;
	localparam logic [1:0] AFT_PAD  = 2'd1;   // block filled by the closing beat
	localparam logic [1:0] AFT_ZERO = 2'd2;   // length did not fit, clear a new block
	localparam logic [1:0] AFT_OUT  = 2'd3;

	logic [2:0]  state_q;
	logic [1:0]  after_q;
	logic [31:0] chain_q [4];
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [5:0]  rnd_q;
	logic [5:0]  bytes_q;
	logic [60:0] count_q;
	logic [5:0]  ptr_q;
	logic        mark_q;
	logic        extra_q;
	logic [1:0]  out_idx_q;

	md5_buf_wr_t buf_wr;
	logic [5:0]  rd_rnd;
	logic [3:0]  msg_idx;
	logic [31:0] msg_word;
	logic [31:0] b_next;
	logic        in_beat;
	logic        has_byte;
	logic [5:0]  pos_next;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign has_byte = s_tuser[0];
	assign pos_next = has_byte ? bytes_q + 6'd1 : bytes_q;

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = chain_q[out_idx_q];
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == 2'd3);

	// Buffer writes: stream bytes in idle, pad bytes in the sweep, length words.
	always_comb begin
		buf_wr.byte_we   = (in_beat && has_byte) || (state_q == ST_PAD);
		buf_wr.byte_addr = (state_q == ST_PAD) ? ptr_q : bytes_q;
		buf_wr.byte_data = (state_q == ST_PAD) ? (mark_q ? PAD_MARK : 8'h00) : s_tdata;
		buf_wr.word_we   = (state_q == ST_LEN0) || (state_q == ST_LEN1);
		buf_wr.word_addr = (state_q == ST_LEN0) ? LEN_LO_WORD : LEN_HI_WORD;
		buf_wr.word_data = (state_q == ST_LEN0) ? {count_q[28:0], 3'b000} : count_q[60:29];
	end

	// The buffer read is registered, so fetch one round ahead: word 0 in the
	// cycle before the rounds start, then the word of the following round.
	assign rd_rnd  = (state_q == ST_ROUND) ? rnd_q + 6'd1 : 6'd0;
	assign msg_idx = md5_msg_idx(rd_rnd);

	md5_blk_buf u_buf (
		.clk     (clk),
		.wr      (buf_wr),
		.rd_addr (msg_idx),
		.rd_data (msg_word)
	);

	md5_round_unit u_round (
		.rnd      (rnd_q),
		.a        (wa_q),
		.b        (wb_q),
		.c        (wc_q),
		.d        (wd_q),
		.msg_word (msg_word),
		.b_next   (b_next)
	);

	// Working words: load from the chain when a compression starts, then
	// rotate through the round unit once per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			wa_q <= wd_q;
			wb_q <= b_next;
			wc_q <= wb_q;
			wd_q <= wc_q;
		end else begin
			wa_q <= chain_q[0];
			wb_q <= chain_q[1];
			wc_q <= chain_q[2];
			wd_q <= chain_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			after_q    <= AFT_IDLE;
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
			rnd_q      <= '0;
			bytes_q    <= '0;
			count_q    <= '0;
			ptr_q      <= '0;
			mark_q     <= 1'b0;
			extra_q    <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (has_byte) begin
							bytes_q <= pos_next;
							count_q <= count_q + 61'd1;
						end
						if (has_byte && bytes_q == 6'd63) begin
							// Block full: compress, pad afterwards if closing.
							rnd_q   <= '0;
							after_q <= s_tlast ? AFT_PAD : AFT_IDLE;
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							ptr_q   <= pos_next;
							mark_q  <= 1'b1;
							extra_q <= (pos_next[5:3] == 3'b111);
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + wa_q;
					chain_q[1] <= chain_q[1] + wb_q;
					chain_q[2] <= chain_q[2] + wc_q;
					chain_q[3] <= chain_q[3] + wd_q;
					case (after_q)
						AFT_PAD: begin
							ptr_q   <= '0;
							mark_q  <= 1'b1;
							extra_q <= 1'b0;
							state_q <= ST_PAD;
						end
						AFT_ZERO: begin
							ptr_q   <= '0;
							mark_q  <= 1'b0;
							extra_q <= 1'b0;
							state_q <= ST_PAD;
						end
						AFT_OUT: begin
							out_idx_q <= '0;
							state_q   <= ST_OUT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					ptr_q  <= ptr_q + 6'd1;
					if (ptr_q == 6'd63) begin
						if (extra_q) begin
							// Length needs a block of its own.
							rnd_q   <= '0;
							after_q <= AFT_ZERO;
							state_q <= ST_ROUND;
						end else begin
							state_q <= ST_LEN0;
						end
					end
				end
				ST_LEN0: begin
					state_q <= ST_LEN1;
				end
				ST_LEN1: begin
					rnd_q   <= '0;
					after_q <= AFT_OUT;
					state_q <= ST_ROUND;
				end
				ST_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 2'd1;
						if (out_idx_q == 2'd3) begin
							// Last word taken: restart for the next message.
							chain_q[0] <= IV_A;
							chain_q[1] <= IV_B;
							chain_q[2] <= IV_C;
							chain_q[3] <= IV_D;
							bytes_q    <= '0;
							count_q    <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
